// ===== rtl/clipped_grid_store_assert.svh =====
// ----------------------------------------------------------------------------
// Grid store assertion macros
// Property macros sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_GRID_STORE_ASSERT_SVH
`define CLIPPED_GRID_STORE_ASSERT_SVH

// same-cycle implication
`define CGS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CGS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cgs_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid store package
// Opcodes, register indexes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package cgs_pkg;

	localparam int OP_W    = 3;
	localparam int COORD_W = 16;
	localparam int RECT_W  = 7;
	localparam int VAL_W   = 32;
	localparam int DIM_W   = 7;
	localparam int IDX_W   = 2;
	// coordinate arithmetic: a 16-bit coordinate plus a rectangle size
	localparam int CRD_W   = 17;

	typedef enum logic [OP_W-1:0] {
		OP_GET   = 3'd0,
		OP_SET   = 3'd1,
		OP_ADD   = 3'd2,
		OP_SUB   = 3'd3,
		OP_FILL  = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ADDR,
		ST_MOD,
		ST_FILL,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/clipped_grid_store.sv =====
// ----------------------------------------------------------------------------
// Clipped grid store
// Bounds-checked 2-D store of signed 32-bit cells with clipped rectangle
// fill and full clear, built around one cell memory and a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Content
// s_*       in   s_tvalid/s_tready  request item (opcode, coordinates, operand)
// m_*       out  m_tvalid/m_tready  result item (cell value, in-range flag)
// cfg_*     in   cfg_we             grid width / grid height write
//
// Get/set/add/subtract in range: accept, address, one memory read-modify-write
// through the shared adder, result. Out of range: the memory step is skipped.
// Fill: one memory write per cycle over the clipped w*h cells. Clear: every cell.
// After reset a clearing pass writes all MAX_COLS*MAX_ROWS cells, s_tready low.
// A result waits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module clipped_grid_store
	import cgs_pkg::*;
#(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // col[15:0] row[31:16] rect_w[38:32] rect_h[45:39]
	                               // operand[77:46] zero[79:78]
	input  logic [2:0]  s_tuser,   // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cell_value[31:0]
	output logic        m_tuser,   // in_range[0]
	input  logic        cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata
);

	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_d;

	logic [DIM_W-1:0] grid_width_q, grid_height_q;

	logic [OP_W-1:0]    op_q;
	logic [COORD_W-1:0] col_q, row_q;
	logic [RECT_W-1:0]  rw_q, rh_q;
	logic [VAL_W-1:0]   operand_q;

	logic [AW-1:0]    addr_q, base_q, clr_q;
	logic [CW-1:0]    xs_q, cx_q;
	logic [CRD_W-1:0] cy_q, xend_q, yend_q;
	logic [VAL_W-1:0] res_q;
	logic             hit_q;

	logic             m_tvalid_q;
	logic [VAL_W-1:0] m_data_q;
	logic             m_hit_q;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [VAL_W-1:0] mem_wdata;

	logic [CRD_W-1:0] w_c, h_c, x0_c, y0_c, xsum_c, ysum_c, xend_c, yend_c;
	logic [AW-1:0]    base_c, addr_c;
	logic             hit_c, fill_empty_c, row_end_c, fill_last_c, clr_last_c;
	logic [VAL_W-1:0] alu_b_c, alu_c;
	logic             out_load, accept;

	// ---------------- coordinate logic
	assign w_c  = (grid_width_q > MAX_COLS) ? CRD_W'(MAX_COLS) : CRD_W'(grid_width_q);
	assign h_c  = (grid_height_q > MAX_ROWS) ? CRD_W'(MAX_ROWS) : CRD_W'(grid_height_q);
	assign x0_c = col_q[COORD_W-1] ? '0 : CRD_W'(col_q);
	assign y0_c = row_q[COORD_W-1] ? '0 : CRD_W'(row_q);

	assign hit_c = !col_q[COORD_W-1] && !row_q[COORD_W-1] && (x0_c < w_c) && (y0_c < h_c);

	assign xsum_c = x0_c + CRD_W'(rw_q);
	assign ysum_c = y0_c + CRD_W'(rh_q);
	assign xend_c = (xsum_c < w_c) ? xsum_c : w_c;
	assign yend_c = (ysum_c < h_c) ? ysum_c : h_c;
	assign fill_empty_c = (x0_c >= w_c) || (y0_c >= h_c) || (rw_q == '0) || (rh_q == '0);

	// row base shared by single-cell address and fill start
	assign base_c = AW'(y0_c[RW-1:0]) * AW'(MAX_COLS);
	assign addr_c = base_c + AW'(x0_c[CW-1:0]);

	assign row_end_c   = (CRD_W'(cx_q) + CRD_W'(1)) == xend_q;
	assign fill_last_c = row_end_c && ((cy_q + CRD_W'(1)) == yend_q);
	assign clr_last_c  = (clr_q == AW'(DEPTH - 1));

	// shared add/subtract unit
	assign alu_b_c = (op_q == OP_SUB) ? ~operand_q : operand_q;
	assign alu_c   = rdata_q + alu_b_c + VAL_W'(op_q == OP_SUB);

	assign accept = s_tvalid && s_tready;

	// ---------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (clr_last_c) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_ADDR;
			end
			ST_ADDR: begin
				unique case (op_q) inside
					OP_GET, OP_SET, OP_ADD, OP_SUB: state_d = hit_c ? ST_MOD : ST_DONE;
					OP_FILL:  state_d = fill_empty_c ? ST_DONE : ST_FILL;
					OP_CLEAR: state_d = ST_CLEAR;
					default:  state_d = ST_DONE;
				endcase
			end
			ST_MOD:   state_d = ST_DONE;
			ST_FILL: begin
				if (fill_last_c) state_d = ST_DONE;
			end
			ST_CLEAR: begin
				if (clr_last_c) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// ---------------- sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_raddr = addr_c;
		out_load  = 1'b0;
		unique case (state_q) inside
			ST_INIT, ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE: s_tready = 1'b1;
			ST_ADDR: ;
			ST_MOD: begin
				mem_we    = (op_q != OP_GET);
				mem_wdata = (op_q == OP_SET) ? operand_q : alu_c;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = base_q + AW'(cx_q);
				mem_wdata = operand_q;
			end
			ST_DONE: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	// ---------------- cell memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	// ---------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			grid_width_q  <= '0;
			grid_height_q <= '0;
			clr_q         <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata;
					REG_GRID_HEIGHT: grid_height_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == ST_INIT || state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			else clr_q <= '0;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// ---------------- payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= s_tuser;
			col_q     <= s_tdata[15:0];
			row_q     <= s_tdata[31:16];
			rw_q      <= s_tdata[38:32];
			rh_q      <= s_tdata[45:39];
			operand_q <= s_tdata[77:46];
		end
		if (state_q == ST_ADDR) begin
			addr_q <= addr_c;
			base_q <= base_c;
			xs_q   <= x0_c[CW-1:0];
			cx_q   <= x0_c[CW-1:0];
			cy_q   <= y0_c;
			xend_q <= xend_c;
			yend_q <= yend_c;
			res_q  <= '0;
			hit_q  <= 1'b0;
		end
		if (state_q == ST_MOD) begin
			res_q <= (op_q == OP_SET) ? operand_q : ((op_q == OP_GET) ? rdata_q : alu_c);
			hit_q <= 1'b1;
		end
		if (state_q == ST_FILL) begin
			if (row_end_c) begin
				cx_q   <= xs_q;
				cy_q   <= cy_q + CRD_W'(1);
				base_q <= base_q + AW'(MAX_COLS);
			end else begin
				cx_q <= cx_q + CW'(1);
			end
		end
		if (out_load) begin
			m_data_q <= res_q;
			m_hit_q  <= hit_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_hit_q;

	// ---------------- assertions
	`include "clipped_grid_store_assert.svh"

	`CGS_ASSERT_NEXT(a_busy_after_item, accept, !s_tready, "item taken while busy")
	`CGS_ASSERT_NOW(a_fill_clipped, state_q == ST_FILL,
		(CRD_W'(cx_q) < xend_q) && (cy_q < yend_q), "fill beyond clip")
	`CGS_ASSERT_NOW(a_hit_single_cell, out_load && hit_q,
		op_q == OP_GET || op_q == OP_SET || op_q == OP_ADD || op_q == OP_SUB,
		"in-range flag on non-cell op")

endmodule

// ===== sim/clipped_grid_store_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid store testbench
// Sends request items over the stream port and checks each result item in
// order against a cycle-free model of the cell grid. The run covers several
// grid sizes, random source and sink idling, and one long sink hold-off.
// ----------------------------------------------------------------------------
module clipped_grid_store_tb;
	import cgs_pkg::*;

	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 180;
	localparam int NUM_PHASES = 8;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [OP_W-1:0] CELL_OPS [4] = '{OP_GET, OP_SET, OP_ADD, OP_SUB};
	localparam logic [VAL_W-1:0] EDGE_VALS [5] =
		'{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h1};

	typedef struct {
		logic [OP_W-1:0]           op;
		logic signed [COORD_W-1:0] col;
		logic signed [COORD_W-1:0] row;
		logic [RECT_W-1:0]         rect_w;
		logic [RECT_W-1:0]         rect_h;
		logic [VAL_W-1:0]          operand;
	} grid_req_t;

	typedef struct {
		logic [VAL_W-1:0] cell_value;
		logic             in_range;
	} grid_resp_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [79:0]      s_tdata = '0;
	logic [2:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [31:0]      m_tdata;
	logic             m_tuser;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_wdata = '0;

	logic [VAL_W-1:0] grid_mem [DEPTH];
	logic [DIM_W-1:0] grid_w = '0;
	logic [DIM_W-1:0] grid_h = '0;

	grid_req_t   pending_reqs [$];
	grid_resp_t  expected_resps [$];
	grid_req_t   req_on_bus;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_req = 0;
	int          hold_ack = 0;
	int          hold_left = 0;
	int          failures = 0;
	int unsigned cycles = 0;

	clipped_grid_store #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// grid update and result for one accepted request
	function automatic grid_resp_t apply_grid_req(grid_req_t r);
		grid_resp_t res;
		int w, h, x0, y0, rw, rh, idx;
		res.cell_value = '0;
		res.in_range = 1'b0;
		w = (grid_w > MAX_COLS) ? MAX_COLS : int'(grid_w);
		h = (grid_h > MAX_ROWS) ? MAX_ROWS : int'(grid_h);
		rw = r.rect_w;
		rh = r.rect_h;
		case (r.op) inside
		OP_GET, OP_SET, OP_ADD, OP_SUB: begin
			if (r.col >= 0 && r.col < w && r.row >= 0 && r.row < h) begin
				idx = r.row * MAX_COLS + r.col;
				if (r.op == OP_SET)
					grid_mem[idx] = r.operand;
				else if (r.op == OP_ADD)
					grid_mem[idx] = grid_mem[idx] + r.operand;
				else if (r.op == OP_SUB)
					grid_mem[idx] = grid_mem[idx] - r.operand;
				res.cell_value = grid_mem[idx];
				res.in_range = 1'b1;
			end
		end
		OP_FILL: begin
			x0 = (r.col < 0) ? 0 : r.col;
			y0 = (r.row < 0) ? 0 : r.row;
			for (int ty = y0; ty < y0 + rh && ty < h; ty++)
				for (int tx = x0; tx < x0 + rw && tx < w; tx++)
					grid_mem[ty * MAX_COLS + tx] = r.operand;
		end
		OP_CLEAR: begin
			foreach (grid_mem[i])
				grid_mem[i] = '0;
		end
		default: ;
		endcase
		return res;
	endfunction

	function automatic grid_req_t make_req(logic [OP_W-1:0] op, int col, int row,
			int rw, int rh, logic [VAL_W-1:0] operand);
		grid_req_t r;
		r.op = op;
		r.col = COORD_W'(col);
		r.row = COORD_W'(row);
		r.rect_w = RECT_W'(rw);
		r.rect_h = RECT_W'(rh);
		r.operand = operand;
		return r;
	endfunction

	// mostly near the grid, some just below zero, some anywhere
	function automatic logic signed [COORD_W-1:0] pick_coord(int span);
		int sel;
		sel = $urandom_range(99);
		if (sel < 80)
			return COORD_W'($urandom_range(span + 1));
		else if (sel < 90)
			return COORD_W'(-int'($urandom_range(3, 1)));
		return COORD_W'($urandom);
	endfunction

	function automatic logic [RECT_W-1:0] pick_rect();
		int sel;
		sel = $urandom_range(99);
		if (sel < 85)
			return RECT_W'($urandom_range(8));
		else if (sel < 98)
			return RECT_W'($urandom_range(64));
		return RECT_W'($urandom_range(127));
	endfunction

	function automatic grid_req_t random_req(int w, int h);
		grid_req_t r;
		int sel;
		sel = $urandom_range(999);
		if (sel < 5)
			r.op = OP_CLEAR;
		else if (sel < 20)
			r.op = $urandom_range(1) ? OP_RSVD7 : OP_RSVD6;
		else if (sel < 120)
			r.op = OP_FILL;
		else
			r.op = CELL_OPS[$urandom_range(3)];
		r.col = pick_coord(w);
		r.row = pick_coord(h);
		r.rect_w = pick_rect();
		r.rect_h = pick_rect();
		r.operand = ($urandom_range(9) == 0) ? EDGE_VALS[$urandom_range(4)] : $urandom;
		return r;
	endfunction

	// source side
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_resps.push_back(apply_grid_req(req_on_bus));
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_on_bus = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, req_on_bus.operand, req_on_bus.rect_h,
						req_on_bus.rect_w, req_on_bus.row, req_on_bus.col};
					s_tuser <= req_on_bus.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side: check results, drive backpressure
	always @(posedge clk) begin : sink
		grid_resp_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_resps.size() == 0) begin
					$display("%0t: unexpected item, cell_value %h in_range %b",
						$time, m_tdata, m_tuser);
					failures++;
				end else begin
					want = expected_resps.pop_front();
					if (m_tdata !== want.cell_value) begin
						$display("%0t: cell_value expected %h actual %h",
							$time, want.cell_value, m_tdata);
						failures++;
					end
					if (m_tuser !== want.in_range) begin
						$display("%0t: in_range expected %b actual %b",
							$time, want.in_range, m_tuser);
						failures++;
					end
				end
			end
			if (hold_ack != hold_req) begin
				hold_ack = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_GRID_WIDTH: grid_w = val;
		REG_GRID_HEIGHT: grid_h = val;
		default: ;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int phase_w [NUM_PHASES];
		int phase_h [NUM_PHASES];
		int pw, ph, ew, eh;
		phase_w = '{0, 127, 64, 1, -1, 64, 1, -1};
		phase_h = '{0, 127, 64, 1, -1, 1, 64, -1};
		foreach (grid_mem[i])
			grid_mem[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// store clearing pass after reset
		do
			@(negedge clk);
		while (!s_tready);

		write_reg(REG_GRID_WIDTH, 7'd64);
		write_reg(REG_GRID_HEIGHT, 7'd64);
		write_reg(REG_UNUSED, 7'd5);
		@(negedge clk);
		pending_reqs.push_back(make_req(OP_GET, 0, 0, 0, 0, 32'h0));
		pending_reqs.push_back(make_req(OP_SET, 0, 0, 0, 0, 32'h7fff_ffff));
		pending_reqs.push_back(make_req(OP_ADD, 0, 0, 0, 0, 32'h1));
		pending_reqs.push_back(make_req(OP_SUB, 0, 0, 0, 0, 32'h1));
		pending_reqs.push_back(make_req(OP_SUB, 0, 0, 0, 0, 32'h8000_0000));
		pending_reqs.push_back(make_req(OP_SET, 63, 63, 0, 0, 32'h8000_0000));
		pending_reqs.push_back(make_req(OP_GET, 63, 63, 0, 0, 32'h0));
		pending_reqs.push_back(make_req(OP_GET, 64, 0, 0, 0, 32'h0));
		pending_reqs.push_back(make_req(OP_GET, 0, 64, 0, 0, 32'h0));
		pending_reqs.push_back(make_req(OP_SET, -1, 0, 0, 0, 32'hdead_beef));
		pending_reqs.push_back(make_req(OP_ADD, 0, -32768, 0, 0, 32'h1));
		pending_reqs.push_back(make_req(OP_SUB, 32767, 32767, 0, 0, 32'h1));
		pending_reqs.push_back(make_req(OP_FILL, -5, -3, 10, 4, 32'h5a5a_5a5a));
		pending_reqs.push_back(make_req(OP_GET, 9, 3, 0, 0, 32'h0));
		pending_reqs.push_back(make_req(OP_GET, 10, 0, 0, 0, 32'h0));
		pending_reqs.push_back(make_req(OP_FILL, 60, 60, 127, 127, 32'hffff_ffff));
		pending_reqs.push_back(make_req(OP_GET, 63, 63, 0, 0, 32'h0));
		pending_reqs.push_back(make_req(OP_FILL, 5, 5, 0, 9, 32'h1111_1111));
		pending_reqs.push_back(make_req(OP_FILL, 5, 5, 9, 0, 32'h2222_2222));
		pending_reqs.push_back(make_req(OP_FILL, 64, 0, 4, 4, 32'h3333_3333));
		pending_reqs.push_back(make_req(OP_RSVD6, 1, 1, 3, 3, $urandom));
		pending_reqs.push_back(make_req(OP_RSVD7, 2, 2, 3, 3, $urandom));
		pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 0, 32'h0));
		pending_reqs.push_back(make_req(OP_GET, 63, 63, 0, 0, 32'h0));
		pending_reqs.push_back(make_req(OP_FILL, 0, 0, 64, 64, 32'h1234_5678));
		pending_reqs.push_back(make_req(OP_GET, 32, 32, 0, 0, 32'h0));

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			pw = (phase_w[p] < 0) ? $urandom_range(20, 1) : phase_w[p];
			ph = (phase_h[p] < 0) ? $urandom_range(20, 1) : phase_h[p];
			write_reg(REG_GRID_WIDTH, DIM_W'(pw));
			write_reg(REG_GRID_HEIGHT, DIM_W'(ph));
			ew = (pw > MAX_COLS) ? MAX_COLS : pw;
			eh = (ph > MAX_ROWS) ? MAX_ROWS : ph;
			@(negedge clk);
			send_idle_pct = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 29 : 0;
			recv_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 29 : 0;
			// long sink hold-off so the block backs up onto its input
			if (p == 2)
				hold_req++;
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_reqs.push_back(random_req(ew, eh));
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
